// File: hw/rtl/cirt_pkg.sv
// Shared constants, codes and types of the chained id remap table.
package cirt_pkg;

    // Field widths.
    localparam int ID_W   = 16;
    localparam int VER_W  = 8;
    localparam int ST_W   = 3;
    localparam int KIND_W = 2;

    // Default sizes for the top-level parameters.
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int HOP_LIMIT_DEF   = 256;

    // Command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Newest version after reset.
    localparam logic [VER_W-1:0] NEWEST_RESET = 8'd3;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_DONE      = 3'd0;
    localparam logic [ST_W-1:0] ST_NO_TABLE  = 3'd1;
    localparam logic [ST_W-1:0] ST_HOP_LIMIT = 3'd2;
    localparam logic [ST_W-1:0] ST_LOADED    = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd4;

    // Command kinds, decided by the front part.
    localparam logic [KIND_W-1:0] KIND_LOAD     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NO_TABLE = 2'd3;

    // Classified command as it travels through the queue.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [VER_W-1:0]  ver;
        logic [ID_W-1:0]   tid;
        logic [VER_W-1:0]  tver;
    } t_cmd;

    // One remap record.
    typedef struct packed {
        logic [ID_W-1:0]  old_id;
        logic [VER_W-1:0] old_ver;
        logic [ID_W-1:0]  new_id;
        logic [VER_W-1:0] new_ver;
    } t_entry;

    // Push request from the front part into the queue.
    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_push;

    // Queue fill status.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// File: hw/rtl/cirt_req_if.sv
// Request channel: valid/ready handshake with the request fields.
interface cirt_req_if import cirt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [ID_W-1:0]  item_id;
    logic [VER_W-1:0] item_version;
    logic [ID_W-1:0]  target_id;
    logic [VER_W-1:0] target_version;

    modport source (
        output valid, req_type, item_id, item_version, target_id, target_version,
        input  ready
    );
    modport sink (
        input  valid, req_type, item_id, item_version, target_id, target_version,
        output ready
    );
endinterface

// File: hw/rtl/cirt_rsp_if.sv
// Response channel: valid/ready handshake with the result fields.
interface cirt_rsp_if import cirt_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] out_id;
    logic [ST_W-1:0] status;

    modport source (
        output valid, out_id, status,
        input  ready
    );
    modport sink (
        input  valid, out_id, status,
        output ready
    );
endinterface

// File: hw/rtl/chained_id_remap_table.sv
// Chained id remap table. Load items append (old id, old version) to
// (new id, new version) records and answer "loaded"; a load into a full
// table answers "table full" and changes nothing. A lookup on an empty
// table answers "no table" at once. Any other lookup scans the loaded
// records one per cycle from the single read port of the record memory,
// starting at index 0; each chain follow restarts the scan, and the chain
// is followed for at most HOP_LIMIT hops. The front part keeps taking
// items into a two-entry queue while the back part works, and a finished
// result waits in an output register.
module chained_id_remap_table import cirt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int HOP_LIMIT   = HOP_LIMIT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cirt_req_if.sink   i_req,
    cirt_rsp_if.source o_rsp
);
    t_push  push;
    t_qstat qstat;
    t_cmd   cmd;
    logic   pop;

    // Accept and classify.
    cirt_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_qstat (qstat),
        .o_push  (push)
    );

    // Command queue.
    cirt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_cmd   (cmd),
        .o_qstat (qstat)
    );

    // Table, scan and result register.
    cirt_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .HOP_LIMIT   (HOP_LIMIT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

    // The queue is never written while it is full.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.push |-> !qstat.full)
        else $error("command pushed into a full queue");

    // The back part takes commands only from a non-empty queue.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("command popped from an empty queue");

    // An accepted item is waiting in the queue on the next cycle.
    a_accept_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !qstat.empty)
        else $error("accepted item missing from the queue");
endmodule

// File: hw/rtl/cirt_front.sv
// Front part: accepts request items and classifies them into commands.
module cirt_front import cirt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cirt_req_if.sink   i_req,
    input  t_qstat     i_qstat,
    output t_push      o_push
);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             accept;
    logic             is_full;
    logic [KIND_W-1:0] kind;

    // An item is taken whenever the queue has room.
    assign i_req.ready = !i_qstat.full;
    assign accept      = i_req.valid && i_req.ready;
    assign is_full     = (r_count == CNT_W'(TABLE_DEPTH));

    // Classify the item from the number of records loaded so far.
    always_comb begin
        n_count = r_count;
        if (!i_req.req_type) begin
            if (is_full) begin
                kind = KIND_FULL;
            end else begin
                kind = KIND_LOAD;
                if (accept) begin
                    n_count = r_count + 1'b1;
                end
            end
        end else if (r_count == '0) begin
            kind = KIND_NO_TABLE;
        end else begin
            kind = KIND_LOOKUP;
        end
    end

    assign o_push.push     = accept;
    assign o_push.cmd.kind = kind;
    assign o_push.cmd.id   = i_req.item_id;
    assign o_push.cmd.ver  = i_req.item_version;
    assign o_push.cmd.tid  = i_req.target_id;
    assign o_push.cmd.tver = i_req.target_version;

    // Record count as seen by the front part.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end
endmodule

// File: hw/rtl/cirt_queue.sv
// Short command queue between the front and back parts.
module cirt_queue import cirt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output t_cmd   o_cmd,
    output t_qstat o_qstat
);
    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_cnt;

    assign o_qstat.full  = (r_cnt == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign o_cmd         = r_slot[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push.push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push.push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Command storage.
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_slot[r_wr_ptr] <= i_push.cmd;
        end
    end
endmodule

// File: hw/rtl/cirt_back.sv
// Back part: holds the record table, runs loads and chained lookups.
module cirt_back import cirt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int HOP_LIMIT   = HOP_LIMIT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  t_qstat     i_qstat,
    output logic       o_pop,
    cirt_rsp_if.source o_rsp
);
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int HOP_W = $clog2(HOP_LIMIT + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    // Record memory with a registered read port.
    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd;

    logic             r_state,     n_state;
    logic [CNT_W-1:0] r_fill,      n_fill;
    logic [VER_W-1:0] r_newest,    n_newest;
    logic [IDX_W-1:0] r_idx,       n_idx;
    logic [HOP_W-1:0] r_hops,      n_hops;
    logic [ID_W-1:0]  r_cur_id,    n_cur_id;
    logic [VER_W-1:0] r_cur_ver,   n_cur_ver;
    logic             r_out_valid, n_out_valid;
    logic [ID_W-1:0]  r_out_id,    n_out_id;
    logic [ST_W-1:0]  r_out_status, n_out_status;

    logic   wr_en;
    t_entry wr_entry;
    logic   hit;
    logic   last;

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.out_id = r_out_id;
    assign o_rsp.status = r_out_status;

    assign wr_entry.old_id  = i_cmd.id;
    assign wr_entry.old_ver = i_cmd.ver;
    assign wr_entry.new_id  = i_cmd.tid;
    assign wr_entry.new_ver = i_cmd.tver;

    // Compare the record just read against the current pair.
    assign hit  = (r_rd.old_id == r_cur_id) && (r_rd.old_ver == r_cur_ver);
    assign last = ((CNT_W'(r_idx) + 1'b1) == r_fill);

    // Sequencer for commands and the table scan.
    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_newest     = r_newest;
        n_idx        = r_idx;
        n_hops       = r_hops;
        n_cur_id     = r_cur_id;
        n_cur_ver    = r_cur_ver;
        n_out_valid  = r_out_valid;
        n_out_id     = r_out_id;
        n_out_status = r_out_status;
        o_pop        = 1'b0;
        wr_en        = 1'b0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty && !r_out_valid) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        KIND_LOAD: begin
                            wr_en  = 1'b1;
                            n_fill = r_fill + 1'b1;
                            if (i_cmd.tver > r_newest) begin
                                n_newest = i_cmd.tver;
                            end
                            n_out_valid  = 1'b1;
                            n_out_id     = '0;
                            n_out_status = ST_LOADED;
                        end
                        KIND_LOOKUP: begin
                            n_cur_id  = i_cmd.id;
                            n_cur_ver = i_cmd.ver;
                            n_hops    = '0;
                            n_idx     = '0;
                            n_state   = S_SCAN;
                        end
                        KIND_FULL: begin
                            n_out_valid  = 1'b1;
                            n_out_id     = '0;
                            n_out_status = ST_FULL;
                        end
                        default: begin
                            n_out_valid  = 1'b1;
                            n_out_id     = '0;
                            n_out_status = ST_NO_TABLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (hit) begin
                    if (r_rd.new_ver == r_newest) begin
                        n_out_valid  = 1'b1;
                        n_out_id     = r_rd.new_id;
                        n_out_status = ST_DONE;
                        n_state      = S_IDLE;
                    end else if (r_hops == HOP_W'(HOP_LIMIT - 1)) begin
                        n_out_valid  = 1'b1;
                        n_out_id     = r_rd.new_id;
                        n_out_status = ST_HOP_LIMIT;
                        n_state      = S_IDLE;
                    end else begin
                        // Follow the chain and rescan from the first record.
                        n_cur_id  = r_rd.new_id;
                        n_cur_ver = r_rd.new_ver;
                        n_hops    = r_hops + 1'b1;
                        n_idx     = '0;
                    end
                end else if (last) begin
                    n_out_valid  = 1'b1;
                    n_out_id     = r_cur_id;
                    n_out_status = ST_DONE;
                    n_state      = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_newest    <= NEWEST_RESET;
            r_idx       <= '0;
            r_hops      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_newest    <= n_newest;
            r_idx       <= n_idx;
            r_hops      <= n_hops;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cur_id     <= n_cur_id;
        r_cur_ver    <= n_cur_ver;
        r_out_id     <= n_out_id;
        r_out_status <= n_out_status;
    end

    // Records are appended at the fill count; the read follows the scan index.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_fill[IDX_W-1:0]] <= wr_entry;
        end
        r_rd <= r_mem[n_idx];
    end
endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the chained id remap table: directed and random items.
`timescale 1ns / 1ps

module tb_top;
    import cirt_pkg::*;

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int HOPS         = HOP_LIMIT_DEF;
    localparam int CLK_PERIOD   = 20;
    localparam int COST_CAP     = 2600;
    localparam int LIMIT_CYCLES = 10_000_000;
    localparam int DRAIN_CYCLES = 600;
    localparam int POOL_N       = 12;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // One expected answer of the block.
    typedef struct packed {
        logic [ID_W-1:0] out_id;
        logic [ST_W-1:0] status;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cirt_req_if req_bus ();
    cirt_rsp_if rsp_bus ();

    chained_id_remap_table #(
        .TABLE_DEPTH (DEPTH),
        .HOP_LIMIT   (HOPS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus.sink),
        .o_rsp   (rsp_bus.source)
    );

    // Shadow copy of the remap records.
    logic [ID_W-1:0]  rec_old_id  [DEPTH];
    logic [VER_W-1:0] rec_old_ver [DEPTH];
    logic [ID_W-1:0]  rec_new_id  [DEPTH];
    logic [VER_W-1:0] rec_new_ver [DEPTH];
    int               rec_count;
    logic [VER_W-1:0] newest_ver;

    t_result pending_results [$];
    logic [ID_W-1:0] id_pool [POOL_N];
    int mismatch_count;
    int cycle_count;
    int burst_left;
    int stall_mode;
    int stall_left;
    int stall_phase;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Follow the chain from one (id, version) pair the way the block does.
    function automatic t_result resolve_lookup(input logic [ID_W-1:0] id_in,
                                               input logic [VER_W-1:0] ver_in,
                                               output int hops);
        logic [ID_W-1:0]  cur_id;
        logic [VER_W-1:0] cur_ver;
        t_result          res;
        bit               finished;
        int               hit;
        int               k;
        hops    = 0;
        cur_id  = id_in;
        cur_ver = ver_in;
        res     = '0;
        if (rec_count == 0 || newest_ver == '0) begin
            res.status = ST_NO_TABLE;
            return res;
        end
        finished = 1'b0;
        while (!finished) begin
            hit = -1;
            for (k = 0; k < rec_count && hit < 0; k++) begin
                if (rec_old_id[k] == cur_id && rec_old_ver[k] == cur_ver) begin
                    hit = k;
                end
            end
            if (hit < 0) begin
                res.out_id = cur_id;
                res.status = ST_DONE;
                finished   = 1'b1;
            end else if (rec_new_ver[hit] == newest_ver) begin
                res.out_id = rec_new_id[hit];
                res.status = ST_DONE;
                finished   = 1'b1;
            end else begin
                cur_id  = rec_new_id[hit];
                cur_ver = rec_new_ver[hit];
                hops++;
                if (hops >= HOPS) begin
                    res.out_id = cur_id;
                    res.status = ST_HOP_LIMIT;
                    finished   = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Append one record to the shadow table, or refuse it when full.
    function automatic t_result record_load(input logic [ID_W-1:0] id,
                                            input logic [VER_W-1:0] ver,
                                            input logic [ID_W-1:0] tid,
                                            input logic [VER_W-1:0] tver);
        t_result res;
        res = '0;
        if (rec_count >= DEPTH) begin
            res.status = ST_FULL;
            return res;
        end
        rec_old_id[rec_count]  = id;
        rec_old_ver[rec_count] = ver;
        rec_new_id[rec_count]  = tid;
        rec_new_ver[rec_count] = tver;
        if (tver > newest_ver) begin
            newest_ver = tver;
        end
        rec_count++;
        res.status = ST_LOADED;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0d cycles: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Offer one item in bursts with idle gaps; record its answer once accepted.
    task automatic send_item(input logic kind, input logic [ID_W-1:0] id,
                             input logic [VER_W-1:0] ver, input logic [ID_W-1:0] tid,
                             input logic [VER_W-1:0] tver);
        int gap;
        int hops;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                req_bus.valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge i_clk);
        req_bus.valid          <= 1'b1;
        req_bus.req_type       <= kind;
        req_bus.item_id        <= id;
        req_bus.item_version   <= ver;
        req_bus.target_id      <= tid;
        req_bus.target_version <= tver;
        do begin
            @(posedge i_clk);
        end while (!req_bus.ready);
        if (kind == REQ_LOOKUP) begin
            pending_results.push_back(resolve_lookup(id, ver, hops));
        end else begin
            pending_results.push_back(record_load(id, ver, tid, tver));
        end
    endtask

    // One random item: mostly chain-building loads and lookups that land on records.
    task automatic send_random_item(input int load_pct);
        logic [ID_W-1:0]  id;
        logic [VER_W-1:0] ver;
        logic [ID_W-1:0]  tid;
        logic [VER_W-1:0] tver;
        t_result          probe;
        int               r;
        int               pick;
        int               hops;
        int               tries;
        bit               ok;
        tid  = 16'($urandom);
        tver = 8'($urandom);
        if ($urandom_range(0, 99) < load_pct) begin
            // Old pair: extend an existing chain, reuse a pool id, or go wide.
            r = $urandom_range(0, 99);
            if (rec_count > 0 && r < 50) begin
                pick = $urandom_range(0, rec_count - 1);
                id   = rec_new_id[pick];
                ver  = rec_new_ver[pick];
            end else if (r < 80) begin
                id  = id_pool[$urandom_range(0, POOL_N - 1)];
                ver = 8'($urandom_range(0, newest_ver));
            end else begin
                id  = 16'($urandom);
                ver = 8'($urandom);
            end
            // New pair: point back at a record, or pick a version near the newest.
            r = $urandom_range(0, 99);
            if (rec_count > 0 && r < 25) begin
                pick = $urandom_range(0, rec_count - 1);
                tid  = rec_old_id[pick];
                tver = rec_old_ver[pick];
            end else begin
                tid = ($urandom_range(0, 1) == 0) ? id_pool[$urandom_range(0, POOL_N - 1)]
                                                   : 16'($urandom);
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    tver = newest_ver;
                end else if (r < 75) begin
                    tver = 8'($urandom_range(0, newest_ver));
                end else if (r < 95) begin
                    tver = (newest_ver < 8'd254) ? newest_ver + 8'd1 : newest_ver;
                end else begin
                    tver = 8'($urandom_range(0, 254));
                end
            end
            send_item(REQ_LOAD, id, ver, tid, tver);
        end else begin
            // Keep lookups whose scan would run far too long off the bus.
            tries = 0;
            do begin
                r = $urandom_range(0, 99);
                if (rec_count > 0 && r < 60) begin
                    pick = $urandom_range(0, rec_count - 1);
                    id   = rec_old_id[pick];
                    ver  = rec_old_ver[pick];
                end else if (r < 80) begin
                    id  = id_pool[$urandom_range(0, POOL_N - 1)];
                    ver = 8'($urandom_range(0, newest_ver));
                end else begin
                    id  = 16'($urandom);
                    ver = 8'($urandom);
                end
                probe = resolve_lookup(id, ver, hops);
                ok    = ((hops + 1) * rec_count <= COST_CAP);
                tries++;
            end while (!ok && tries < 4);
            if (!ok) begin
                id  = 16'($urandom);
                ver = 8'($urandom);
            end
            send_item(REQ_LOOKUP, id, ver, tid, tver);
        end
    endtask

    task automatic test_empty_table();
        send_item(REQ_LOOKUP, 16'h0000, 8'h00, 16'hFFFF, 8'hFF);
        send_item(REQ_LOOKUP, 16'hFFFF, 8'hFF, 16'h0000, 8'h00);
    endtask

    task automatic test_direct_and_chained();
        // Direct hit on a record whose new version is the newest.
        send_item(REQ_LOAD, 16'h0000, 8'h00, 16'h1234, 8'd3);
        send_item(REQ_LOOKUP, 16'h0000, 8'h00, 16'h0000, 8'h00);
        // One hop through an older version.
        send_item(REQ_LOAD, 16'hFFFF, 8'hFF, 16'h0100, 8'd1);
        send_item(REQ_LOAD, 16'h0100, 8'd1, 16'hABCD, 8'd3);
        send_item(REQ_LOOKUP, 16'hFFFF, 8'hFF, 16'h0000, 8'h00);
        // No record matches at all.
        send_item(REQ_LOOKUP, 16'h4242, 8'd3, 16'hFFFF, 8'hFF);
        // A duplicate old pair loses to the earlier record.
        send_item(REQ_LOAD, 16'h0000, 8'h00, 16'h9999, 8'd3);
        send_item(REQ_LOOKUP, 16'h0000, 8'h00, 16'h0000, 8'h00);
        // The chain runs into a pair with no record.
        send_item(REQ_LOAD, 16'h0200, 8'd2, 16'h0300, 8'd2);
        send_item(REQ_LOOKUP, 16'h0200, 8'd2, 16'h0000, 8'h00);
    endtask

    task automatic test_hop_limit();
        // A record that maps onto itself.
        send_item(REQ_LOAD, 16'h5555, 8'd1, 16'h5555, 8'd1);
        send_item(REQ_LOOKUP, 16'h5555, 8'd1, 16'h0000, 8'h00);
        // Two records that point at each other.
        send_item(REQ_LOAD, 16'h6000, 8'd2, 16'h6001, 8'd0);
        send_item(REQ_LOAD, 16'h6001, 8'd0, 16'h6000, 8'd2);
        send_item(REQ_LOOKUP, 16'h6000, 8'd2, 16'h0000, 8'h00);
    endtask

    task automatic test_newest_version_raise();
        // Raising the newest version turns old final records into links.
        send_item(REQ_LOAD, 16'h7000, 8'd4, 16'hFFFF, 8'd20);
        send_item(REQ_LOAD, 16'h8000, 8'h00, 16'h0000, 8'h00);
        send_item(REQ_LOOKUP, 16'h7000, 8'd4, 16'h0000, 8'h00);
        send_item(REQ_LOOKUP, 16'h0000, 8'h00, 16'h0000, 8'h00);
        send_item(REQ_LOOKUP, 16'h8000, 8'h00, 16'h0000, 8'h00);
    endtask

    task automatic test_random_mix();
        int n;
        for (n = 0; n < 420 && rec_count < DEPTH - 8; n++) begin
            send_random_item(55);
        end
    endtask

    task automatic test_fill_table();
        while (rec_count < DEPTH - 1) begin
            send_item(REQ_LOAD, 16'($urandom), 8'($urandom), 16'($urandom),
                      8'($urandom_range(0, newest_ver)));
        end
        // Last free slot takes the highest version; then loads are refused.
        send_item(REQ_LOAD, 16'hC0DE, 8'h80, 16'hFFFF, 8'hFF);
        send_item(REQ_LOOKUP, 16'hC0DE, 8'h80, 16'h0000, 8'h00);
        send_item(REQ_LOAD, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF);
        send_item(REQ_LOAD, 16'h0000, 8'h00, 16'h0000, 8'h00);
        send_item(REQ_LOAD, 16'h1234, 8'd3, 16'h5678, 8'd9);
        send_item(REQ_LOOKUP, 16'h0000, 8'h00, 16'h0000, 8'h00);
    endtask

    task automatic test_random_tail();
        int n;
        for (n = 0; n < 80; n++) begin
            send_random_item(30);
        end
    endtask

    // Receiver: ready follows a pattern that changes every so often.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end else begin
            stall_left--;
        end
        stall_phase++;
        case (stall_mode)
            0: begin
                rsp_bus.ready <= 1'b1;
            end
            1: begin
                rsp_bus.ready <= ($urandom_range(0, 99) < 70);
            end
            2: begin
                rsp_bus.ready <= (stall_phase % 3 != 0);
            end
            default: begin
                rsp_bus.ready <= ($urandom_range(0, 15) == 0);
            end
        endcase
    end

    // Check each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result id=%h status=%0d",
                                          rsp_bus.out_id, rsp_bus.status));
            end else begin
                want = pending_results.pop_front();
                if (rsp_bus.out_id !== want.out_id) begin
                    report_mismatch($sformatf("out_id got %h want %h",
                                              rsp_bus.out_id, want.out_id));
                end
                if (rsp_bus.status !== want.status) begin
                    report_mismatch($sformatf("status got %0d want %0d",
                                              rsp_bus.status, want.status));
                end
            end
        end
    end

    // Run-away guard.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int k;
        i_rst_n                = 1'b0;
        req_bus.valid          = 1'b0;
        req_bus.req_type       = REQ_LOAD;
        req_bus.item_id        = '0;
        req_bus.item_version   = '0;
        req_bus.target_id      = '0;
        req_bus.target_version = '0;
        rsp_bus.ready          = 1'b0;
        rec_count              = 0;
        newest_ver             = NEWEST_RESET;
        mismatch_count         = 0;
        cycle_count            = 0;
        burst_left             = 0;
        stall_mode             = 0;
        stall_left             = 0;
        stall_phase            = 0;
        id_pool[0]             = 16'h0000;
        id_pool[1]             = 16'hFFFF;
        for (k = 2; k < POOL_N; k++) begin
            id_pool[k] = 16'($urandom);
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_direct_and_chained();
        test_hop_limit();
        test_newest_version_raise();
        test_random_mix();
        test_fill_table();
        test_random_tail();

        @(negedge i_clk);
        req_bus.valid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
